@@ design/ckbc_pkg.sv @@
// Shared constants, field widths and width helpers for the color-key blob centroid block.
package ckbc_pkg;

    localparam int CHAN_W      = 8;
    localparam int COORD_W     = 10;
    localparam int COUNT_W     = 21;
    localparam int MAX_DIM_DEF = 1024;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CHAN_W-1:0] CHAN_FULL = 8'hFF;
    localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'h00;

    // input word layout
    localparam int IN_BLUE_LSB  = 0;
    localparam int IN_GREEN_LSB = IN_BLUE_LSB + CHAN_W;
    localparam int IN_RED_LSB   = IN_GREEN_LSB + CHAN_W;
    localparam int IN_ROW_LSB   = IN_RED_LSB + CHAN_W;
    localparam int IN_COL_LSB   = IN_ROW_LSB + COORD_W;
    localparam int IN_TDATA_W   = 48;

    // output word layout
    localparam int OUT_FIELDS_W = 2 * (2 * COORD_W + COUNT_W + 1);
    localparam int OUT_TDATA_W  = 88;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    function automatic int cnt_width(input int max_dim);
        return $clog2(max_dim * max_dim + 1);
    endfunction

    function automatic int sum_width(input int max_dim);
        return cnt_width(max_dim) + COORD_W;
    endfunction

    // one frame record: green row sum, col sum, count, then the same for red
    function automatic int snap_width(input int max_dim);
        return 2 * (2 * sum_width(max_dim) + cnt_width(max_dim));
    endfunction

endpackage

@@ design/ckbc_front.sv @@
// Pixel front end: color classification and per-frame blob accumulation.
module ckbc_front #(
    parameter int MAX_DIM = ckbc_pkg::MAX_DIM_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [ckbc_pkg::IN_TDATA_W-1:0]        s_tdata,
    input  logic                                   s_tlast,
    output logic                                   snap_valid,
    input  logic                                   snap_ready,
    output logic [ckbc_pkg::snap_width(MAX_DIM)-1:0] snap_data
);
    import ckbc_pkg::*;

    localparam int CNT_W = cnt_width(MAX_DIM);
    localparam int SUM_W = sum_width(MAX_DIM);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_DIM * MAX_DIM);

    logic [SUM_W-1:0] g_rs_reg, g_cs_reg, r_rs_reg, r_cs_reg;
    logic [CNT_W-1:0] g_tot_reg, r_tot_reg;
    logic [SUM_W-1:0] g_rs_next, g_cs_next, r_rs_next, r_cs_next;
    logic [CNT_W-1:0] g_tot_next, r_tot_next;

    logic [CHAN_W-1:0]  blue, green, red;
    logic [COORD_W-1:0] row, col;
    logic               fire, in_frame, is_green, is_red;

    assign blue  = s_tdata[IN_BLUE_LSB +: CHAN_W];
    assign green = s_tdata[IN_GREEN_LSB +: CHAN_W];
    assign red   = s_tdata[IN_RED_LSB +: CHAN_W];
    assign row   = s_tdata[IN_ROW_LSB +: COORD_W];
    assign col   = s_tdata[IN_COL_LSB +: COORD_W];

    assign s_tready = snap_ready;
    assign fire     = s_tvalid && s_tready;

    assign in_frame = (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM);
    assign is_green = in_frame && blue == CHAN_ZERO && green == CHAN_FULL && red == CHAN_ZERO;
    assign is_red   = in_frame && blue == CHAN_ZERO && green == CHAN_ZERO && red == CHAN_FULL;

    always_comb
    begin
        g_rs_next  = g_rs_reg;
        g_cs_next  = g_cs_reg;
        g_tot_next = g_tot_reg;
        r_rs_next  = r_rs_reg;
        r_cs_next  = r_cs_reg;
        r_tot_next = r_tot_reg;
        if (is_green && g_tot_reg < CAP)
        begin
            g_rs_next  = g_rs_reg + SUM_W'(row);
            g_cs_next  = g_cs_reg + SUM_W'(col);
            g_tot_next = g_tot_reg + CNT_W'(1);
        end
        if (is_red && r_tot_reg < CAP)
        begin
            r_rs_next  = r_rs_reg + SUM_W'(row);
            r_cs_next  = r_cs_reg + SUM_W'(col);
            r_tot_next = r_tot_reg + CNT_W'(1);
        end
    end

    assign snap_valid = fire && s_tlast;
    assign snap_data  = {r_tot_next, r_cs_next, r_rs_next, g_tot_next, g_cs_next, g_rs_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_rs_reg  <= '0;
            g_cs_reg  <= '0;
            g_tot_reg <= '0;
            r_rs_reg  <= '0;
            r_cs_reg  <= '0;
            r_tot_reg <= '0;
        end
        else if (fire)
        begin
            if (s_tlast)
            begin
                g_rs_reg  <= '0;
                g_cs_reg  <= '0;
                g_tot_reg <= '0;
                r_rs_reg  <= '0;
                r_cs_reg  <= '0;
                r_tot_reg <= '0;
            end
            else
            begin
                g_rs_reg  <= g_rs_next;
                g_cs_reg  <= g_cs_next;
                g_tot_reg <= g_tot_next;
                r_rs_reg  <= r_rs_next;
                r_cs_reg  <= r_cs_next;
                r_tot_reg <= r_tot_next;
            end
        end
    end

    a_clear_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s_tlast) |=> (g_tot_reg == '0 && r_tot_reg == '0))
        else $error("accumulators not cleared after frame end");

    a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
        (g_tot_reg <= CAP && r_tot_reg <= CAP))
        else $error("blob count above cap");

    a_snap_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid |-> snap_ready)
        else $error("frame record pushed into full queue");

endmodule

@@ design/ckbc_fifo.sv @@
// Short register queue carrying frame records from the front end to the divider.
module ckbc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ckbc_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

@@ design/ckbc_back.sv @@
// Back end: four-lane restoring divider for the centroids and the result register.
module ckbc_back #(
    parameter int MAX_DIM = ckbc_pkg::MAX_DIM_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     q_valid,
    output logic                                     q_ready,
    input  logic [ckbc_pkg::snap_width(MAX_DIM)-1:0] q_data,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [ckbc_pkg::OUT_TDATA_W-1:0]         m_tdata
);
    import ckbc_pkg::*;

    localparam int CNT_W  = cnt_width(MAX_DIM);
    localparam int SUM_W  = sum_width(MAX_DIM);
    localparam int LANES  = 4;
    localparam int STEP_W = $clog2(COORD_W);

    localparam int G_RS  = 0;
    localparam int G_CS  = G_RS + SUM_W;
    localparam int G_TOT = G_CS + SUM_W;
    localparam int R_RS  = G_TOT + CNT_W;
    localparam int R_CS  = R_RS + SUM_W;
    localparam int R_TOT = R_CS + SUM_W;

    localparam int LANE_GR = 0;
    localparam int LANE_GC = 1;
    localparam int LANE_RR = 2;
    localparam int LANE_RC = 3;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [SUM_W-1:0]   rem_reg [LANES];
    logic [SUM_W-1:0]   div_reg [LANES];
    logic [COORD_W-1:0] quo_reg [LANES];
    logic [CNT_W-1:0]   g_tot_reg, r_tot_reg;

    logic [SUM_W-1:0] diff [LANES];
    logic [LANES-1:0] ge;

    logic               m_tvalid_reg;
    logic [COORD_W-1:0] g_row_reg, g_col_reg, r_row_reg, r_col_reg;
    logic [COUNT_W-1:0] g_count_reg, r_count_reg;
    logic               g_found_reg, r_found_reg;

    logic g_found, r_found, load_out;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            ge[l]   = rem_reg[l] >= div_reg[l];
            diff[l] = rem_reg[l] - div_reg[l];
        end
    end

    assign q_ready  = state_reg == S_IDLE;
    assign g_found  = g_tot_reg != '0;
    assign r_found  = r_tot_reg != '0;
    assign load_out = state_reg == S_DONE && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(COORD_W - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (load_out)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_valid)
        begin
            g_tot_reg         <= q_data[G_TOT +: CNT_W];
            r_tot_reg         <= q_data[R_TOT +: CNT_W];
            rem_reg[LANE_GR]  <= q_data[G_RS +: SUM_W];
            rem_reg[LANE_GC]  <= q_data[G_CS +: SUM_W];
            rem_reg[LANE_RR]  <= q_data[R_RS +: SUM_W];
            rem_reg[LANE_RC]  <= q_data[R_CS +: SUM_W];
            div_reg[LANE_GR]  <= SUM_W'({q_data[G_TOT +: CNT_W], {(COORD_W - 1){1'b0}}});
            div_reg[LANE_GC]  <= SUM_W'({q_data[G_TOT +: CNT_W], {(COORD_W - 1){1'b0}}});
            div_reg[LANE_RR]  <= SUM_W'({q_data[R_TOT +: CNT_W], {(COORD_W - 1){1'b0}}});
            div_reg[LANE_RC]  <= SUM_W'({q_data[R_TOT +: CNT_W], {(COORD_W - 1){1'b0}}});
        end
        else if (state_reg == S_DIV)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (ge[l])
                begin
                    rem_reg[l] <= diff[l];
                end
                div_reg[l] <= div_reg[l] >> 1;
                quo_reg[l] <= {quo_reg[l][COORD_W-2:0], ge[l]};
            end
        end

        if (load_out)
        begin
            g_row_reg   <= g_found ? quo_reg[LANE_GR] : '0;
            g_col_reg   <= g_found ? quo_reg[LANE_GC] : '0;
            g_count_reg <= COUNT_W'(g_tot_reg);
            g_found_reg <= g_found;
            r_row_reg   <= r_found ? quo_reg[LANE_RR] : '0;
            r_col_reg   <= r_found ? quo_reg[LANE_RC] : '0;
            r_count_reg <= COUNT_W'(r_tot_reg);
            r_found_reg <= r_found;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}},
                       r_found_reg, r_count_reg, r_col_reg, r_row_reg,
                       g_found_reg, g_count_reg, g_col_reg, g_row_reg};

    a_empty_blob_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && (!g_found_reg || !r_found_reg)) |->
        ((g_found_reg || (g_row_reg == '0 && g_col_reg == '0)) &&
         (r_found_reg || (r_row_reg == '0 && r_col_reg == '0))))
        else $error("empty blob with nonzero centroid");

    a_div_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && step_reg == STEP_W'(COORD_W - 1)) |=> state_reg == S_DONE)
        else $error("divider did not finish on the last step");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> m_tvalid_reg)
        else $error("finished result not presented");

endmodule

@@ design/color_key_blob_centroid_top.sv @@
// Top level of the color-key blob centroid block: front end, frame queue and divider.
//
//  port group   dir   tdata fields (lsb up)                                  tlast
//  s_*          in    blue, green, red, row, col, pad to 48 bits             frame_end
//  m_*          out   green_row, green_col, green_count, green_found,        -
//                     red_row, red_col, red_count, red_found, pad to 88 bits
//
// Pixels are taken one per cycle while the frame queue has room; the frame-end pixel is folded in
// before its record is queued. With the divider idle, the record is loaded, runs COORD_W restoring
// steps shared by the four lanes and is registered as the output word. The divider takes a new
// record only once its result word is loaded; s_tready drops while the two-entry queue is full.
// A low m_tready holds the result word, then the divider, then fills the queue.
// rst_n clears the accumulators, the queue and the output valid asynchronously.
module color_key_blob_centroid_top #(
    parameter int MAX_DIM = ckbc_pkg::MAX_DIM_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ckbc_pkg::IN_TDATA_W-1:0]  s_tdata,  // blue, green, red, row, col
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ckbc_pkg::OUT_TDATA_W-1:0] m_tdata   // green row/col/count/found, red same
);
    import ckbc_pkg::*;

    localparam int SNAP_W = snap_width(MAX_DIM);

    logic              snap_valid, snap_ready;
    logic [SNAP_W-1:0] snap_data;
    logic              q_valid, q_ready;
    logic [SNAP_W-1:0] q_data;

    ckbc_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap_data  (snap_data)
    );

    ckbc_fifo #(
        .WIDTH (SNAP_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (snap_valid),
        .in_ready  (snap_ready),
        .in_data   (snap_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    ckbc_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
